### design/lcs_pkg.sv
// Package for the LRU key/value store: sizes, codes and the structs
// passed between the match array, the recency tracker and the top level.
// No dependencies.
package lcs_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CFG_W    = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [0:0] {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  // Result of the parallel key compare
  typedef struct packed {
    logic hit;
    idx_t idx;
  } lookup_t;

  // Slot chosen for a new key
  typedef struct packed {
    logic insert;
    idx_t slot;
  } alloc_t;

endpackage

### design/lcs_req_if.sv
// Request channel of the LRU store: valid/ready plus func, key and value.
// Depends on lcs_pkg for the field widths.
interface lcs_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [lcs_pkg::KEY_W-1:0]  key;
  logic signed [lcs_pkg::VAL_W-1:0]  value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

### design/lcs_rsp_if.sv
// Response channel of the LRU store: valid/ready plus found and read_value.
// Depends on lcs_pkg for the field widths.
interface lcs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [lcs_pkg::VAL_W-1:0]  read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

### design/lcs_cam.sv
// Key store with a parallel compare against all valid entries.
// Depends on lcs_pkg.
module lcs_cam (
  input  logic                           clk_i,
  input  logic [lcs_pkg::KEY_W-1:0]      key_i,
  input  logic [lcs_pkg::CAPACITY-1:0]   valid_i,
  input  lcs_pkg::alloc_t                alloc_i,
  output lcs_pkg::lookup_t               lookup_o
);

  logic [lcs_pkg::KEY_W-1:0] keys_q [lcs_pkg::CAPACITY];
  logic [lcs_pkg::CAPACITY-1:0] match;

  always_ff @(posedge clk_i) begin
    if (alloc_i.insert) begin
      keys_q[alloc_i.slot] <= key_i;
    end
  end

  always_comb begin
    lookup_o = '0;
    for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
      match[i] = valid_i[i] && (keys_q[i] == key_i);
    end
    // lowest matching slot wins
    for (int i = lcs_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_o.hit = 1'b1;
        lookup_o.idx = lcs_pkg::IDX_W'(i);
      end
    end
  end

endmodule

### design/lcs_lru.sv
// Recency tracker: valid marks, per-entry ranks (0 = most recent), fill count,
// eviction and free-slot choice. Depends on lcs_pkg.
module lcs_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           func_i,
  input  logic [lcs_pkg::CFG_W-1:0]      cap_cfg_i,
  input  lcs_pkg::lookup_t               lookup_i,
  output logic [lcs_pkg::CAPACITY-1:0]   valid_o,
  output lcs_pkg::alloc_t                alloc_o
);

  logic [lcs_pkg::CAPACITY-1:0] valid_q, valid_d, valid_ev;
  lcs_pkg::idx_t                rank_q [lcs_pkg::CAPACITY];
  lcs_pkg::idx_t                rank_d [lcs_pkg::CAPACITY];
  lcs_pkg::cnt_t                used_q, used_d;
  logic [lcs_pkg::CMP_W-1:0]    cfg_ext;
  lcs_pkg::cnt_t                cap, cap_m1;
  logic                         full;
  logic                         is_put;
  lcs_pkg::idx_t                hit_rank;
  lcs_pkg::idx_t                free_slot;
  logic                         free_ok;

  // clamp the configured capacity into 1..CAPACITY
  always_comb begin
    cfg_ext = lcs_pkg::CMP_W'(cap_cfg_i);
    if (cfg_ext == '0) begin
      cap = lcs_pkg::CNT_W'(1);
    end else if (cfg_ext > lcs_pkg::CMP_W'(lcs_pkg::CAPACITY)) begin
      cap = lcs_pkg::CNT_W'(lcs_pkg::CAPACITY);
    end else begin
      cap = lcs_pkg::CNT_W'(cfg_ext);
    end
    cap_m1 = cap - lcs_pkg::CNT_W'(1);
    full   = (used_q >= cap);
  end

  always_comb begin
    is_put = (func_i == lcs_pkg::FUNC_PUT);
    // drop entries at or beyond the capacity edge when the store is full
    for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
      valid_ev[i] = valid_q[i] && !(full && (lcs_pkg::CNT_W'(rank_q[i]) >= cap_m1));
    end
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = lcs_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        free_slot = lcs_pkg::IDX_W'(i);
        free_ok   = 1'b1;
      end
    end
    hit_rank = rank_q[lookup_i.idx];

    alloc_o.insert = step_i && !lookup_i.hit && is_put && free_ok;
    alloc_o.slot   = free_slot;

    valid_d = valid_q;
    rank_d  = rank_q;
    used_d  = used_q;
    if (step_i && lookup_i.hit) begin
      // promote: newer entries age by one
      for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
        if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + lcs_pkg::IDX_W'(1);
        end
      end
      rank_d[lookup_i.idx] = '0;
    end else if (alloc_o.insert) begin
      valid_d = valid_ev;
      for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
        if (valid_ev[i]) begin
          rank_d[i] = rank_q[i] + lcs_pkg::IDX_W'(1);
        end
      end
      valid_d[free_slot] = 1'b1;
      rank_d[free_slot]  = '0;
      used_d = (full ? cap_m1 : used_q) + lcs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      rank_q  <= rank_d;
    end
  end

  assign valid_o = valid_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(used_q))
    else $error("fill count differs from number of valid entries");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= lcs_pkg::CNT_W'(lcs_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_insert_sets_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_o.insert |=> valid_q[$past(alloc_o.slot)] && (rank_q[$past(alloc_o.slot)] == '0))
    else $error("inserted slot not valid and most recent");

  a_hit_promotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && lookup_i.hit) |=> rank_q[$past(lookup_i.idx)] == '0)
    else $error("hit entry not made most recent");
`endif

endmodule

### design/lru_cache_store.sv
// Fully associative key/value store with LRU replacement.
// A request is held in the input register, then one pass of compare and rank
// update writes the result register, which drives the valid response.
// Throughput: one request per cycle; a new request enters every cycle that the
// result register is free or being drained. Reset clears valid marks, ranks,
// fill count and handshake state at once; capacity register resets to 16.
module lru_cache_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lcs_pkg::CFG_W-1:0]   cfg_wdata_i,
  lcs_req_if.sink                     req_i,
  lcs_rsp_if.source                   rsp_o
);

  logic [lcs_pkg::CFG_W-1:0]   cap_cfg_q;
  logic                        req_vq;
  logic                        func_q;
  logic [lcs_pkg::KEY_W-1:0]   key_q;
  logic [lcs_pkg::VAL_W-1:0]   value_q;
  logic                        rsp_vq;
  logic                        found_q;
  logic [lcs_pkg::VAL_W-1:0]   read_q;
  logic                        adv;
  logic                        is_put;
  logic [lcs_pkg::VAL_W-1:0]   values_q [lcs_pkg::CAPACITY];
  logic [lcs_pkg::CAPACITY-1:0] valid;
  lcs_pkg::lookup_t            lookup;
  lcs_pkg::alloc_t             alloc;

  assign adv         = req_vq && (!rsp_vq || rsp_o.ready);
  assign req_i.ready = !req_vq || adv;
  assign is_put      = (func_q == lcs_pkg::FUNC_PUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= lcs_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cap_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vq <= 1'b0;
      rsp_vq <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_vq <= req_i.valid;
      end
      if (adv) begin
        rsp_vq <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= req_i.func;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    if (adv) begin
      found_q <= lookup.hit;
      read_q  <= (lookup.hit && !is_put) ? values_q[lookup.idx] : '1;
    end
  end

  // value store: overwrite on a put hit, fill on a new key
  always_ff @(posedge clk_i) begin
    if (adv && lookup.hit && is_put) begin
      values_q[lookup.idx] <= value_q;
    end else if (alloc.insert) begin
      values_q[alloc.slot] <= value_q;
    end
  end

  lcs_cam u_cam (
    .clk_i    (clk_i),
    .key_i    (key_q),
    .valid_i  (valid),
    .alloc_i  (alloc),
    .lookup_o (lookup)
  );

  lcs_lru u_lru (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .func_i    (func_q),
    .cap_cfg_i (cap_cfg_q),
    .lookup_i  (lookup),
    .valid_o   (valid),
    .alloc_o   (alloc)
  );

  assign rsp_o.valid      = rsp_vq;
  assign rsp_o.found      = found_q;
  assign rsp_o.read_value = read_q;

`ifndef SYNTHESIS
  a_miss_reads_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vq && !found_q) |-> (read_q == '1))
    else $error("miss response carries a value");

  a_insert_only_on_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc.insert |-> (adv && is_put && !lookup.hit))
    else $error("insertion outside a put miss");

  a_free_output_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_vq |-> req_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

### test/tb.sv
// Testbench for lru_cache_store: directed and random get/put traffic on the
// request channel, responses checked against a shadow LRU store model.
// Depends on lcs_pkg, lcs_req_if, lcs_rsp_if and the lru_cache_store RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [lcs_pkg::KEY_W-1:0] word_t;

  typedef struct packed {
    logic          found;
    logic [lcs_pkg::VAL_W-1:0] read_value;
  } lookup_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [lcs_pkg::CFG_W-1:0] cfg_wdata_i;

  lcs_req_if req ();
  lcs_rsp_if rsp ();

  lru_cache_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the store
  word_t            shadow_key  [lcs_pkg::CAPACITY];
  word_t            shadow_val  [lcs_pkg::CAPACITY];
  bit               shadow_vld  [lcs_pkg::CAPACITY];
  int unsigned      shadow_rank [lcs_pkg::CAPACITY];
  int unsigned      shadow_used;
  logic [lcs_pkg::CFG_W-1:0] shadow_cap_reg;

  lookup_rsp_t pending_rsp_q[$];
  int          err_cnt = 0;
  bit          calm = 1'b0;

  function automatic void clear_shadow();
    for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_used    = 0;
    shadow_cap_reg = lcs_pkg::CFG_RESET;
  endfunction

  function automatic int unsigned held_limit(input logic [lcs_pkg::CFG_W-1:0] c);
    int unsigned n;
    n = c;
    if (n == 0) n = 1;
    if (n > lcs_pkg::CAPACITY) n = lcs_pkg::CAPACITY;
    return n;
  endfunction

  function automatic lookup_rsp_t predict_access(input lcs_pkg::func_e f, input word_t k,
                                                 input word_t v);
    int          hit;
    int          slot;
    int unsigned cap;
    int unsigned r;
    lookup_rsp_t res;
    hit  = -1;
    slot = -1;
    res.found      = 1'b0;
    res.read_value = '1;
    for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
      if (hit < 0 && shadow_vld[i] && shadow_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      // age every entry newer than the hit, then make the hit most recent
      r = shadow_rank[hit];
      for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
        if (shadow_vld[i] && shadow_rank[i] < r) shadow_rank[i]++;
      end
      shadow_rank[hit] = 0;
      res.found = 1'b1;
      if (f == lcs_pkg::FUNC_PUT) shadow_val[hit] = v;
      else res.read_value = shadow_val[hit];
    end else if (f == lcs_pkg::FUNC_PUT) begin
      cap = held_limit(shadow_cap_reg);
      // drop everything at or past the last kept rank
      if (shadow_used >= cap) begin
        for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
          if (shadow_vld[i] && shadow_rank[i] >= cap - 1) shadow_vld[i] = 1'b0;
        end
        shadow_used = cap - 1;
      end
      for (int i = 0; i < lcs_pkg::CAPACITY; i++) begin
        if (shadow_vld[i]) shadow_rank[i]++;
        else if (slot < 0) slot = i;
      end
      shadow_key[slot]  = k;
      shadow_val[slot]  = v;
      shadow_vld[slot]  = 1'b1;
      shadow_rank[slot] = 0;
      shadow_used++;
    end
    return res;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request and hold it until the transfer
  task automatic send_req(input lcs_pkg::func_e f, input word_t k, input word_t v);
    req.valid <= 1'b1;
    req.func  <= f;
    req.key   <= k;
    req.value <= v;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    pending_rsp_q.push_back(predict_access(f, k, v));
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [lcs_pkg::CFG_W-1:0] c);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cap_reg = c;
  endtask

  task automatic test_empty_lookup();
    send_req(lcs_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0000, 32'h1234_5678);
  endtask

  task automatic test_insert_hit();
    send_req(lcs_pkg::FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(lcs_pkg::FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(lcs_pkg::FUNC_PUT, 32'h0000_0000, 32'hffff_ffff);
    send_req(lcs_pkg::FUNC_PUT, 32'hffff_ffff, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'hffff_ffff, 32'h0000_0000);
  endtask

  task automatic test_update();
    send_req(lcs_pkg::FUNC_PUT, 32'h0000_0000, 32'h5a5a_a5a5);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0000, 32'hffff_ffff);
    send_req(lcs_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000);
  endtask

  // Lower the capacity below the fill level, then insert a new key
  task automatic test_shrink_evict();
    wait_idle();
    write_capacity(5'd2);
    send_req(lcs_pkg::FUNC_PUT, 32'h0bad_cafe, 32'h0000_0001);
    send_req(lcs_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'hffff_ffff, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h0bad_cafe, 32'h0000_0000);
  endtask

  // Zero capacity holds a single entry
  task automatic test_capacity_floor();
    wait_idle();
    write_capacity(5'd0);
    send_req(lcs_pkg::FUNC_PUT, 32'h0000_0011, 32'h0000_00aa);
    send_req(lcs_pkg::FUNC_PUT, 32'h0000_0022, 32'h0000_00bb);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0011, 32'h0000_0000);
    send_req(lcs_pkg::FUNC_GET, 32'h0000_0022, 32'h0000_0000);
  endtask

  task automatic test_random_phase(input logic [lcs_pkg::CFG_W-1:0] c, input int n_items,
                                   input bit pause_mid);
    word_t pool[$];
    int    pool_len;
    word_t k;
    lcs_pkg::func_e f;
    wait_idle();
    write_capacity(c);
    // a few more keys than fit, so hits, misses and evictions all occur
    pool_len = held_limit(c) + $urandom_range(1, 6);
    for (int i = 0; i < pool_len; i++) pool.push_back(pick_word());
    for (int n = 0; n < n_items; n++) begin
      if (pause_mid && n == n_items / 2) wait_idle();
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_len - 1)];
      f = ($urandom_range(0, 99) < 55) ? lcs_pkg::FUNC_PUT : lcs_pkg::FUNC_GET;
      send_req(f, k, pick_word());
    end
  endtask

  always @(posedge clk_i) begin
    lookup_rsp_t want;
    if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 40)
          $display("%0t: response with none pending: found=%0b read_value=%h",
                   $time, rsp.found, rsp.read_value);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp.found !== want.found) begin
          err_cnt++;
          if (err_cnt <= 40)
            $display("%0t: found mismatch: expected %0b actual %0b",
                     $time, want.found, rsp.found);
        end
        if (rsp.read_value !== want.read_value) begin
          err_cnt++;
          if (err_cnt <= 40)
            $display("%0t: read_value mismatch: expected %h actual %h",
                     $time, want.read_value, rsp.read_value);
        end
      end
    end
  end

  initial begin : drive_ready
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 6) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run_tests
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    req.valid   = 1'b0;
    req.func    = lcs_pkg::FUNC_GET;
    req.key     = '0;
    req.value   = '0;
    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_insert_hit();
    test_update();
    test_shrink_evict();
    test_capacity_floor();

    test_random_phase(5'd31, 40, 1'b0);
    test_random_phase(5'd1, 40, 1'b0);
    test_random_phase(5'd16, 40, 1'b1);
    test_random_phase(5'd3, 40, 1'b0);
    test_random_phase(5'd17, 40, 1'b0);
    test_random_phase(5'd0, 30, 1'b0);
    test_random_phase(5'($urandom_range(0, 31)), 40, 1'b0);
    test_random_phase(5'd7, 40, 1'b0);
    test_random_phase(5'd2, 30, 1'b0);
    // closing stretch without idling on either side
    calm = 1'b1;
    test_random_phase(5'd16, 60, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/lcs_pkg.sv
design/lcs_req_if.sv
design/lcs_rsp_if.sv
design/lcs_cam.sv
design/lcs_lru.sv
design/lru_cache_store.sv
test/tb.sv
